/* rtl/icdf_pkg.sv */
// shared types and constants of the inverse-cdf table sampler
// no dependencies
package icdf_pkg;

  localparam int unsigned IDX_W     = 12;
  localparam int unsigned BIN_W     = 24;
  localparam int unsigned CUM_W     = 33;
  localparam int unsigned UNI_W     = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned PROD_W    = UNI_W + BIN_W;
  localparam int unsigned DIV_STEPS = BIN_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_LOADED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INSIDE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BEYOND = 2'd2;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] entry_index;
    logic [BIN_W-1:0] entry_bin;
    logic [CUM_W-1:0] entry_cum_prob;
    logic [UNI_W-1:0] uniform;
  } item_t;

  typedef struct packed {
    logic [BIN_W-1:0]    sample_value;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [CUM_W-1:0] cum;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

endpackage

/* rtl/icdf_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module icdf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/inverse_cdf_table_sampler.sv */
// top level of the inverse-cdf table sampler: table ram, scan sequencer, divider
// depends on icdf_pkg and icdf_ram
//
// usage:
//   an item is taken at a clock edge with start_i high and busy_o low.
//   a load item writes one table entry (ignored at or beyond TABLE_DEPTH) and
//   its result strobes on done_o in the next cycle; busy_o stays low, so loads
//   may follow every cycle.
//   a sample item scans the table one entry per cycle from entry 0, through
//   the ram's single read port, until an entry's cumulative value reaches the
//   uniform or last_entry is passed. a hit at entry 0 gives that entry's bin
//   with no interpolation; a hit at a later entry is interpolated through a
//   multiply state, a bit-serial restoring divider state and a state that
//   forms the value. beyond-table results strobe once the last entry has been
//   scanned without a hit. busy_o is high until the strobe cycle.
//   each result strobes done_o for one cycle; result_o holds it until the next.
//   last_entry is written over the cfg channel, which is always ready.
//   reset clears last_entry and the sequencer; the table is not cleared and
//   holds nothing meaningful until loaded.
module inverse_cdf_table_sampler
  import icdf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  item_t            item_i,
  output logic             done_o,
  output result_t          result_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_data_i
);

  localparam int unsigned AW      = $clog2(TABLE_DEPTH);
  localparam int unsigned ENTRY_W = BIN_W + CUM_W;

  state_e state_q, state_d;

  logic [IDX_W-1:0]  last_entry_q;
  logic [UNI_W-1:0]  u_q, u_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [CUM_W-1:0]  c0_q, c0_d;
  logic [BIN_W-1:0]  b0_q, b0_d;
  logic [UNI_W-1:0]  num_q, num_d;
  logic [CUM_W-1:0]  den_q, den_d;
  logic [BIN_W-1:0]  mag_q, mag_d;
  logic              up_q, up_d;
  logic [CUM_W-1:0]  rem_q, rem_d;
  logic [BIN_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  result_t           out_q, out_d;

  logic              accept;
  logic [31:0]       le_full;
  logic [AW-1:0]     le;
  logic [31:0]       widx_full;
  logic              we;
  logic [AW-1:0]     raddr;
  entry_t            wentry;
  entry_t            rentry;
  logic [ENTRY_W-1:0] rdata;
  logic              hit;
  logic [CUM_W-1:0]  diff_u;
  logic [PROD_W-1:0] prod;
  logic [CUM_W:0]    trial;
  logic [CUM_W:0]    trial_sub;
  logic              trial_ge;
  logic [BIN_W:0]    q_adj;
  logic [BIN_W:0]    q_lim;
  logic [BIN_W-1:0]  interp;

  assign busy_o      = state_q != ST_IDLE;
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign result_o    = out_q;

  assign le_full = (32'(last_entry_q) >= 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH - 1)
                                                            : 32'(last_entry_q);
  assign le      = le_full[AW-1:0];

  assign widx_full = 32'(item_i.entry_index);
  assign we        = accept && (item_i.cmd == CMD_LOAD) && (widx_full < 32'(TABLE_DEPTH));
  assign wentry    = '{bin: item_i.entry_bin, cum: item_i.entry_cum_prob};
  assign raddr     = (state_q == ST_SCAN) ? idx_q + AW'(1) : '0;

  icdf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (widx_full[AW-1:0]),
    .wdata_i (wentry),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rentry = entry_t'(rdata);
  assign hit    = rentry.cum >= {1'b0, u_q};
  assign diff_u = {1'b0, u_q} - c0_q;
  assign prod   = PROD_W'(num_q) * PROD_W'(mag_q);

  // one restoring step of the bit-serial divider
  assign trial     = {rem_q, quo_q[BIN_W-1]};
  assign trial_ge  = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  // floor when rising, ceil then clamp when falling
  assign q_adj  = up_q ? {1'b0, quo_q} : {1'b0, quo_q} + (BIN_W + 1)'(rem_q != '0);
  assign q_lim  = (q_adj > {1'b0, b0_q}) ? {1'b0, b0_q} : q_adj;
  assign interp = up_q ? b0_q + quo_q : b0_q - q_lim[BIN_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (item_i.cmd == CMD_SAMPLE)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_d = (idx_q == '0) ? ST_IDLE : ST_MUL;
        end else if (idx_q == le) begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    u_d    = u_q;
    idx_d  = idx_q;
    c0_d   = c0_q;
    b0_d   = b0_q;
    num_d  = num_q;
    den_d  = den_q;
    mag_d  = mag_q;
    up_d   = up_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    out_d  = out_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          u_d   = item_i.uniform;
          idx_d = '0;
          if (item_i.cmd == CMD_LOAD) begin
            done_d = 1'b1;
            out_d  = '{sample_value: '0, status: STATUS_LOADED};
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          if (idx_q == '0) begin
            done_d = 1'b1;
            out_d  = '{sample_value: rentry.bin, status: STATUS_INSIDE};
          end else begin
            num_d = diff_u[UNI_W-1:0];
            den_d = rentry.cum - c0_q;
            up_d  = rentry.bin >= b0_q;
            mag_d = (rentry.bin >= b0_q) ? rentry.bin - b0_q : b0_q - rentry.bin;
          end
        end else if (idx_q == le) begin
          done_d = 1'b1;
          out_d  = '{sample_value: rentry.bin, status: STATUS_BEYOND};
        end else begin
          c0_d  = rentry.cum;
          b0_d  = rentry.bin;
          idx_d = idx_q + AW'(1);
        end
      end
      ST_MUL: begin
        rem_d = {1'b0, prod[PROD_W-1:BIN_W]};
        quo_d = prod[BIN_W-1:0];
        cnt_d = '0;
      end
      ST_DIV: begin
        rem_d = trial_ge ? trial_sub[CUM_W-1:0] : trial[CUM_W-1:0];
        quo_d = {quo_q[BIN_W-2:0], trial_ge};
        cnt_d = cnt_q + CNT_W'(1);
      end
      ST_FIN: begin
        done_d = 1'b1;
        out_d  = '{sample_value: interp, status: STATUS_INSIDE};
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      done_q       <= 1'b0;
      last_entry_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        last_entry_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    u_q   <= u_d;
    idx_q <= idx_d;
    c0_q  <= c0_d;
    b0_q  <= b0_d;
    num_q <= num_d;
    den_q <= den_d;
    mag_q <= mag_d;
    up_q  <= up_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

endmodule

/* rtl/icdf_checker.sv */
// port-level checks of the inverse-cdf table sampler, bound to the top level
// depends on icdf_pkg and inverse_cdf_table_sampler
module icdf_checker
  import icdf_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input item_t            item_i,
  input logic             done_o,
  input result_t          result_o,
  input logic             cfg_valid_i,
  input logic             cfg_ready_o,
  input logic [IDX_W-1:0] cfg_data_i
);

  // load item answers in the next cycle with a zero value
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && item_i.cmd == CMD_LOAD |=>
      done_o && result_o.status == STATUS_LOADED && result_o.sample_value == '0)
    else $error("load item without its result");

  // sample item holds the block busy with no result in the next cycle
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && item_i.cmd == CMD_SAMPLE |=> busy_o && !done_o)
    else $error("sample item not held busy");

  // the block leaves busy only together with a sample result
  a_busy_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o && result_o.status != STATUS_LOADED)
    else $error("busy dropped without a sample result");

  // a sample result is shown only after busy
  a_sample_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status != STATUS_LOADED |-> $past(busy_o) && !busy_o)
    else $error("sample result outside a busy period");

endmodule

bind inverse_cdf_table_sampler icdf_checker u_icdf_checker (.*);
